### rtl/core/hgbt_pkg.sv
`timescale 1ns / 1ps
// Package for the hotspot grid brush table: sizing constants, reset values,
// operation codes, register indices and the sequencer state type.
package hgbt_pkg;
    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int ID_BITS    = 16;
    localparam int MAX_RADIUS = 7;

    localparam logic [15:0] RESET_SPACING = 16'd100;
    localparam logic [6:0]  RESET_DIM     = 7'd64;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_SPACING  = 3'd2,
        REG_WIDE     = 3'd3,
        REG_HIGH     = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_CHECK,
        ST_CENTER_RD,
        ST_CENTER_WAIT,
        ST_CENTER,
        ST_BR_RD,
        ST_BR_WAIT,
        ST_BR_WR,
        ST_DONE
    } t_state;
endpackage

### rtl/core/hotspot_grid_brush_table_unit.sv
`timescale 1ns / 1ps
// Hotspot grid brush table: top level. Depends on hgbt_pkg and hgbt_ram.
//
// A grid of up to MAX_COLS x MAX_ROWS cells over a rectangle of logical
// coordinates. Each word carries an op (add, delete, toggle brush, or query),
// a point, an id and a brush radius, and produces one result word: in_range,
// whether the center cell was occupied, its id, and the occupied count after
// the edit. The block handles one word at a time. A point is mapped to a cell
// by a shared restoring divider that takes one quotient bit per cycle, one
// axis after the other. The brush then walks (2r+1)^2 cells through a
// single-port cell memory with read, wait and write steps per cell (a cell
// off the grid skips the wait); a query or an out-of-range point skips the
// brush walk. After reset the occupied memory is cleared one cell a cycle,
// all MAX_COLS*MAX_ROWS cells, before the first word is taken; configuration
// writes are accepted at any time, but should only be made while idle.
module hotspot_grid_brush_table_unit #(
    parameter int MAX_COLS   = hgbt_pkg::MAX_COLS,
    parameter int MAX_ROWS   = hgbt_pkg::MAX_ROWS,
    parameter int ID_BITS    = hgbt_pkg::ID_BITS,
    parameter int MAX_RADIUS = hgbt_pkg::MAX_RADIUS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [23:0] i_point_x,
    input  logic [23:0] i_point_y,
    input  logic [15:0] i_new_id,
    input  logic [2:0]  i_brush_radius,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_in_range,
    output logic        o_found,
    output logic [15:0] o_found_id,
    output logic [12:0] o_occupied_count
);
    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = $clog2(MAX_COLS + 1) + 1; // signed column range
    localparam int RW     = $clog2(MAX_ROWS + 1) + 1;
    localparam int CXW    = (CW > RW ? CW : RW) + 6;  // brush coordinates
    localparam int MEMW   = ID_BITS + 1;              // occupied bit + id
    localparam int DW     = 25;                       // difference width
    localparam logic [2:0] RMAX = (MAX_RADIUS > 7) ? 3'd7 : 3'(MAX_RADIUS);

    // configuration registers
    logic signed [23:0] r_org_x, r_org_y;
    logic [15:0]        r_spacing;
    logic [6:0]         r_wide, r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_spacing <= hgbt_pkg::RESET_SPACING;
            r_wide    <= hgbt_pkg::RESET_DIM;
            r_high    <= hgbt_pkg::RESET_DIM;
        end else if (i_cfg_we) begin
            case (hgbt_pkg::t_reg'(i_cfg_index))
                hgbt_pkg::REG_ORIGIN_X: r_org_x   <= i_cfg_data;
                hgbt_pkg::REG_ORIGIN_Y: r_org_y   <= i_cfg_data;
                hgbt_pkg::REG_SPACING:  r_spacing <= i_cfg_data[15:0];
                hgbt_pkg::REG_WIDE:     r_wide    <= i_cfg_data[6:0];
                hgbt_pkg::REG_HIGH:     r_high    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // effective sizes, clamped to the stored grid
    logic [10:0] eff_cols, eff_rows;
    logic [15:0] sp;
    always_comb begin
        eff_cols = (32'(r_wide) > MAX_COLS) ? 11'(MAX_COLS) : 11'(r_wide);
        eff_rows = (32'(r_high) > MAX_ROWS) ? 11'(MAX_ROWS) : 11'(r_high);
        sp       = (r_spacing == '0) ? 16'd1 : r_spacing;
    end

    // sequencer and datapath registers
    hgbt_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [1:0]       r_op, n_op;
    logic [23:0]      r_py, n_py;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [2:0]       r_rad, n_rad;
    logic signed [DW-1:0] r_rem, n_rem;     // divider partial remainder
    logic [DW-1:0]    r_quo, n_quo;         // dividend shifted out / quotient
    logic [4:0]       r_dcnt, n_dcnt;
    logic             r_neg, n_neg;         // difference below zero
    logic [DW-1:0]    r_cx, n_cx;
    logic             r_negx, n_negx;
    logic             r_inr, n_inr;
    logic             r_fnd, n_fnd;
    logic [15:0]      r_fid, n_fid;
    logic             r_add, n_add;
    logic signed [CXW-1:0] r_bx, n_bx, r_by, n_by;
    logic [12:0]      r_total, n_total;
    logic             r_ovalid, n_ovalid;

    // memory port
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [MEMW-1:0] mem_wdata, mem_rdata;

    hgbt_ram #(.WIDTH(MEMW), .DEPTH(CELLS)) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hgbt_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
        end
        r_op <= n_op; r_py <= n_py; r_id <= n_id; r_rad <= n_rad;
        r_rem <= n_rem; r_quo <= n_quo; r_dcnt <= n_dcnt; r_neg <= n_neg;
        r_cx <= n_cx; r_negx <= n_negx; r_inr <= n_inr; r_fnd <= n_fnd;
        r_fid <= n_fid; r_add <= n_add; r_bx <= n_bx; r_by <= n_by;
    end

    // one restoring divide step: shared by both axes
    logic signed [DW:0] trial;
    logic signed [DW-1:0] rem_sh;
    always_comb begin
        rem_sh = {r_rem[DW-2:0], r_quo[DW-1]};
        trial  = {rem_sh[DW-1], rem_sh} - $signed({1'b0, 9'd0, sp});
    end

    // brush coordinate checks
    logic signed [CXW-1:0] bx_hi, by_hi;
    logic bx_ok, by_ok;
    logic [AW-1:0] b_addr, c_addr;
    logic [CXW-1:0] cy_w;
    always_comb begin
        cy_w  = CXW'(r_quo);
        bx_hi = $signed(CXW'(r_cx)) + $signed(CXW'(r_rad));
        by_hi = $signed(cy_w) + $signed(CXW'(r_rad));
        bx_ok = (r_bx >= 0) && (r_bx < $signed(CXW'(eff_cols)));
        by_ok = (r_by >= 0) && (r_by < $signed(CXW'(eff_rows)));
        b_addr = AW'(32'(unsigned'(r_by)) * MAX_COLS + 32'(unsigned'(r_bx)));
        c_addr = AW'(32'(r_quo) * MAX_COLS + 32'(r_cx));
    end

    assign o_stall = (r_state != hgbt_pkg::ST_IDLE);

    always_comb begin
        logic signed [24:0] dx;
        dx = '0;
        n_state = r_state; n_clr = r_clr; n_op = r_op; n_py = r_py;
        n_id = r_id; n_rad = r_rad; n_rem = r_rem; n_quo = r_quo;
        n_dcnt = r_dcnt; n_neg = r_neg; n_cx = r_cx; n_negx = r_negx;
        n_inr = r_inr; n_fnd = r_fnd; n_fid = r_fid; n_add = r_add;
        n_bx = r_bx; n_by = r_by; n_total = r_total; n_ovalid = r_ovalid;
        mem_we = 1'b0; mem_addr = r_clr; mem_wdata = '0;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            hgbt_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (32'(r_clr) == CELLS - 1) begin
                    n_state = hgbt_pkg::ST_IDLE;
                end
            end
            hgbt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    // start with x: load difference, count bits
                    dx     = $signed({i_point_x[23], i_point_x}) -
                             $signed({r_org_x[23], r_org_x});
                    n_op   = i_op;
                    n_py   = i_point_y;
                    n_id   = ID_BITS'(i_new_id);
                    n_rad  = (i_brush_radius > RMAX) ? RMAX : i_brush_radius;
                    n_neg  = dx[24];
                    n_quo  = unsigned'(dx);
                    n_rem  = '0;
                    n_dcnt = '0;
                    n_state = hgbt_pkg::ST_DIV_X;
                end
            end
            hgbt_pkg::ST_DIV_X, hgbt_pkg::ST_DIV_Y: begin
                if (trial[DW]) begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end else begin
                    n_rem = trial[DW-1:0];
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == 5'(DW - 1)) begin
                    if (r_state == hgbt_pkg::ST_DIV_X) begin
                        n_cx   = n_quo;
                        n_negx = r_neg;
                        dx     = $signed({r_py[23], r_py}) -
                                 $signed({r_org_y[23], r_org_y});
                        n_neg  = dx[24];
                        n_quo  = unsigned'(dx);
                        n_rem  = '0;
                        n_dcnt = '0;
                        n_state = hgbt_pkg::ST_DIV_Y;
                    end else begin
                        n_state = hgbt_pkg::ST_CHECK;
                    end
                end
            end
            hgbt_pkg::ST_CHECK: begin
                // quotient below the dimension is the same as d < count*sp
                n_inr = !r_negx && !r_neg &&
                        (r_cx < DW'(eff_cols)) && (r_quo < DW'(eff_rows));
                if (n_inr) begin
                    n_state = hgbt_pkg::ST_CENTER_RD;
                end else begin
                    n_fnd = 1'b0; n_fid = '0;
                    n_state = hgbt_pkg::ST_DONE;
                end
            end
            hgbt_pkg::ST_CENTER_RD: begin
                mem_addr = c_addr;
                n_state  = hgbt_pkg::ST_CENTER_WAIT;
            end
            hgbt_pkg::ST_CENTER_WAIT: begin
                mem_addr = c_addr;
                n_state  = hgbt_pkg::ST_CENTER;
            end
            hgbt_pkg::ST_CENTER: begin
                n_fnd = mem_rdata[MEMW-1];
                n_fid = mem_rdata[MEMW-1] ? 16'(mem_rdata[ID_BITS-1:0]) : 16'd0;
                n_bx  = $signed(CXW'(r_cx)) - $signed(CXW'(r_rad));
                n_by  = $signed(cy_w) - $signed(CXW'(r_rad));
                case (hgbt_pkg::t_op'(r_op))
                    hgbt_pkg::OP_ADD:    n_add = 1'b1;
                    hgbt_pkg::OP_DELETE: n_add = 1'b0;
                    hgbt_pkg::OP_TOGGLE: n_add = !mem_rdata[MEMW-1];
                    default:             n_add = 1'b0;
                endcase
                n_state = (hgbt_pkg::t_op'(r_op) == hgbt_pkg::OP_QUERY) ?
                          hgbt_pkg::ST_DONE : hgbt_pkg::ST_BR_RD;
            end
            hgbt_pkg::ST_BR_RD: begin
                mem_addr = b_addr;
                if (bx_ok && by_ok) begin
                    n_state = hgbt_pkg::ST_BR_WAIT;
                end else begin
                    n_state = hgbt_pkg::ST_BR_WR;
                end
            end
            hgbt_pkg::ST_BR_WAIT: begin
                mem_addr = b_addr;
                n_state  = hgbt_pkg::ST_BR_WR;
            end
            hgbt_pkg::ST_BR_WR: begin
                mem_addr = b_addr;
                if (bx_ok && by_ok) begin
                    if (r_add && !mem_rdata[MEMW-1]) begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, r_id};
                        n_total   = r_total + 1'b1;
                    end else if (!r_add && mem_rdata[MEMW-1]) begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b0, mem_rdata[ID_BITS-1:0]};
                        n_total   = r_total - 1'b1;
                    end
                end
                // advance: y inner, x outer
                n_state = hgbt_pkg::ST_BR_RD;
                if (r_by == by_hi) begin
                    n_by = $signed(cy_w) - $signed(CXW'(r_rad));
                    n_bx = r_bx + 1'b1;
                    if (r_bx == bx_hi) begin
                        n_state = hgbt_pkg::ST_DONE;
                    end
                end else begin
                    n_by = r_by + 1'b1;
                end
            end
            hgbt_pkg::ST_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_state  = hgbt_pkg::ST_IDLE;
                end
            end
            default: n_state = hgbt_pkg::ST_IDLE;
        endcase
    end

    // hold the result word until taken
    logic        r_o_inr, r_o_fnd;
    logic [15:0] r_o_fid;
    logic [12:0] r_o_cnt;
    always_ff @(posedge i_clk) begin
        if (r_state == hgbt_pkg::ST_DONE && (!r_ovalid || !i_stall)) begin
            r_o_inr <= r_inr;
            r_o_fnd <= r_fnd;
            r_o_fid <= r_fid;
            r_o_cnt <= r_total;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_in_range       = r_o_inr;
    assign o_found          = r_o_fnd;
    assign o_found_id       = r_o_fid;
    assign o_occupied_count = r_o_cnt;
endmodule

### rtl/core/hgbt_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module hgbt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### bench/tb_hotspot_grid_brush_table_unit.sv
`timescale 1ns / 1ps
// Testbench for hotspot_grid_brush_table_unit: directed table, then random words.
// Depends on hgbt_pkg and the block's RTL; predicts results with its own grid model.
module tb_hotspot_grid_brush_table_unit;
    import hgbt_pkg::*;

    localparam int GRID_CELLS = MAX_COLS * MAX_ROWS;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_op;
    logic [23:0] i_point_x;
    logic [23:0] i_point_y;
    logic [15:0] i_new_id;
    logic [2:0]  i_brush_radius;
    logic        o_valid;
    logic        i_stall;
    logic        o_in_range;
    logic        o_found;
    logic [15:0] o_found_id;
    logic [12:0] o_occupied_count;

    hotspot_grid_brush_table_unit dut (.*);

    typedef struct packed {
        logic        in_range;
        logic        found;
        logic [15:0] found_id;
        logic [12:0] occupied_count;
    } t_cell_report;

    typedef struct {
        t_op         op;
        logic [23:0] px;
        logic [23:0] py;
        logic [15:0] id;
        logic [2:0]  radius;
        bit          typed;
        t_cell_report report;
    } t_brush_row;

    // shadow grid and register copy
    bit          shadow_occ [GRID_CELLS];
    logic [15:0] shadow_id [GRID_CELLS];
    int          shadow_total;
    longint      grid_org_x;
    longint      grid_org_y;
    int          grid_spacing;
    int          grid_wide;
    int          grid_high;

    t_cell_report pending_reports[$];
    int           fail_count;
    bit           drain_hold;      // receiver holds off while set
    bit           sender_paused;
    bit           no_idle;         // stretch without idling

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint sext24(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    // map one axis to a cell index, -1 when outside
    function automatic int axis_to_cell(longint p, longint org, int count);
        longint sp;
        longint d;
        sp = (grid_spacing == 0) ? 1 : grid_spacing;
        d  = p - org;
        if (d < 0 || d >= longint'(count) * sp) return -1;
        return int'(d / sp);
    endfunction

    function automatic t_cell_report predict_brush(t_op op, logic [23:0] px,
                                                   logic [23:0] py, logic [15:0] id,
                                                   logic [2:0] radius);
        t_cell_report rep;
        int cols;
        int rows;
        int cx;
        int cy;
        int r;
        int idx;
        bit add;
        cols = (grid_wide > MAX_COLS) ? MAX_COLS : grid_wide;
        rows = (grid_high > MAX_ROWS) ? MAX_ROWS : grid_high;
        r    = (radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
        rep  = '0;
        cx   = axis_to_cell(sext24(px), grid_org_x, cols);
        cy   = axis_to_cell(sext24(py), grid_org_y, rows);
        if (cx >= 0 && cy >= 0) begin
            idx = cy * MAX_COLS + cx;
            rep.in_range = 1'b1;
            rep.found    = shadow_occ[idx];
            if (shadow_occ[idx]) rep.found_id = shadow_id[idx];
            add = (op == OP_ADD) || (op == OP_TOGGLE && !shadow_occ[idx]);
            if (op != OP_QUERY) begin
                for (int x = cx - r; x <= cx + r; x++) begin
                    for (int y = cy - r; y <= cy + r; y++) begin
                        if (x < 0 || x >= cols || y < 0 || y >= rows) continue;
                        idx = y * MAX_COLS + x;
                        if (add && !shadow_occ[idx]) begin
                            shadow_occ[idx] = 1'b1;
                            shadow_id[idx]  = id;
                            shadow_total++;
                        end else if (!add && shadow_occ[idx]) begin
                            shadow_occ[idx] = 1'b0;
                            shadow_total--;
                        end
                    end
                end
            end
        end
        rep.occupied_count = 13'(shadow_total);
        return rep;
    endfunction

    // drive one word; hold until accepted, valid stays up for a following word
    task automatic send_word(t_op op, logic [23:0] px, logic [23:0] py,
                             logic [15:0] id, logic [2:0] radius);
        while (!no_idle && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_point_x      <= px;
        i_point_y      <= py;
        i_new_id       <= id;
        i_brush_radius <= radius;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_reports.push_back(predict_brush(op, px, py, id, radius));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        // a query finishes fast, but allow the clear and brush tail to settle
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg index, logic [23:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        case (index)
            REG_ORIGIN_X: grid_org_x   = sext24(value);
            REG_ORIGIN_Y: grid_org_y   = sext24(value);
            REG_SPACING:  grid_spacing = int'(value[15:0]);
            REG_WIDE:     grid_wide    = int'(value[6:0]);
            REG_HIGH:     grid_high    = int'(value[6:0]);
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [23:0] ox, logic [23:0] oy, logic [15:0] sp,
                            logic [6:0] w, logic [6:0] h);
        wait_drained();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_SPACING, {8'd0, sp});
        write_reg(REG_WIDE, {17'd0, w});
        write_reg(REG_HIGH, {17'd0, h});
        i_cfg_we <= 1'b0;
    endtask

    // random point: mostly inside the grid, sometimes just past an edge or anywhere
    function automatic logic [23:0] pick_coord(longint org, int count);
        longint sp;
        longint p;
        int sel;
        sp  = (grid_spacing == 0) ? 1 : grid_spacing;
        sel = $urandom_range(9);
        if (sel == 0) return 24'($urandom);
        if (sel == 1) p = org - 1 - $urandom_range(3);
        else if (sel == 2) p = org + longint'(count) * sp + $urandom_range(1) - 1;
        else p = org + longint'($urandom_range(count > 0 ? count - 1 : 0)) * sp
                     + $urandom_range(int'(sp - 1));
        return 24'(p);
    endfunction

    task automatic random_words(int count);
        t_op op;
        for (int n = 0; n < count; n++) begin
            op = t_op'($urandom_range(3));
            send_word(op, pick_coord(grid_org_x, grid_wide),
                      pick_coord(grid_org_y, grid_high),
                      16'($urandom), ($urandom_range(9) < 7) ? 3'($urandom_range(2))
                                                              : 3'($urandom));
        end
    endtask

    // receiver: random stalls, long hold while drain_hold is set; check in order
    initial begin
        t_cell_report got;
        t_cell_report want;
        i_stall = 1'b1;
        @(negedge i_clk);
        forever begin
            i_stall <= drain_hold || (!no_idle && $urandom_range(99) < 34);
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got = {o_in_range, o_found, o_found_id, o_occupied_count};
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (got.in_range !== want.in_range) begin
                        $display("%0t: in_range exp %0d got %0d", $time,
                                 want.in_range, got.in_range);
                        fail_count++;
                    end
                    if (got.found !== want.found) begin
                        $display("%0t: found exp %0d got %0d", $time,
                                 want.found, got.found);
                        fail_count++;
                    end
                    if (got.found_id !== want.found_id) begin
                        $display("%0t: found_id exp %0h got %0h", $time,
                                 want.found_id, got.found_id);
                        fail_count++;
                    end
                    if (got.occupied_count !== want.occupied_count) begin
                        $display("%0t: occupied_count exp %0d got %0d", $time,
                                 want.occupied_count, got.occupied_count);
                        fail_count++;
                    end
                end
            end
            @(negedge i_clk);
        end
    end

    // directed table; typed rows carry an expected result that is checked against the model
    t_brush_row brush_rows[$];

    task automatic add_row(t_op op, logic [23:0] px, logic [23:0] py, logic [15:0] id,
                           logic [2:0] r, bit typed = 0, t_cell_report rep = '0);
        t_brush_row row;
        row = '{op, px, py, id, r, typed, rep};
        brush_rows.push_back(row);
    endtask

    initial begin
        t_cell_report model_rep;
        fail_count   = 0;
        drain_hold   = 1'b0;
        sender_paused = 1'b0;
        no_idle      = 1'b0;
        shadow_total = 0;
        foreach (shadow_occ[k]) shadow_occ[k] = 1'b0;
        grid_org_x = 0; grid_org_y = 0; grid_spacing = 100;
        grid_wide = 64; grid_high = 64;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_op = OP_ADD; i_point_x = '0; i_point_y = '0;
        i_new_id = '0; i_brush_radius = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: 64x64 grid, spacing 100, origin 0
        add_row(OP_QUERY, 24'd0, 24'd0, 16'd0, 3'd0, 1, '{1'b1, 1'b0, 16'd0, 13'd0});
        add_row(OP_ADD, 24'd0, 24'd0, 16'hFFFF, 3'd0, 1, '{1'b1, 1'b0, 16'd0, 13'd1});
        add_row(OP_QUERY, 24'd99, 24'd99, 16'd0, 3'd0, 1,
                '{1'b1, 1'b1, 16'hFFFF, 13'd1});
        // far edge and beyond: 6400 is outside
        add_row(OP_ADD, 24'd6400, 24'd0, 16'd1, 3'd7, 1, '{1'b0, 1'b0, 16'd0, 13'd1});
        add_row(OP_ADD, 24'hFFFFFF, 24'd0, 16'd1, 3'd7, 1, '{1'b0, 1'b0, 16'd0, 13'd1});
        add_row(OP_ADD, 24'h7FFFFF, 24'h800000, 16'd1, 3'd7);
        add_row(OP_ADD, 24'd6399, 24'd6399, 16'h5A5A, 3'd7);
        add_row(OP_ADD, 24'd3200, 24'd3200, 16'h0001, 3'd7);
        add_row(OP_TOGGLE, 24'd3200, 24'd3200, 16'h1234, 3'd3);
        add_row(OP_TOGGLE, 24'd3200, 24'd3200, 16'hABCD, 3'd3);
        add_row(OP_DELETE, 24'd3250, 24'd3150, 16'd0, 3'd1);
        add_row(OP_QUERY, 24'd3200, 24'd3200, 16'd0, 3'd0);
        add_row(OP_DELETE, 24'd0, 24'd0, 16'd0, 3'd7);
        add_row(OP_DELETE, 24'd3200, 24'd3200, 16'd0, 3'd7);
        add_row(OP_DELETE, 24'd6399, 24'd6399, 16'd0, 3'd7);
        add_row(OP_QUERY, 24'd0, 24'd0, 16'd0, 3'd0, 1, '{1'b1, 1'b0, 16'd0, 13'd0});

        foreach (brush_rows[k]) begin
            model_rep = brush_rows[k].report;
            send_word(brush_rows[k].op, brush_rows[k].px, brush_rows[k].py,
                      brush_rows[k].id, brush_rows[k].radius);
            // typed rows must agree with the prediction that was queued
            if (brush_rows[k].typed && pending_reports[$] != model_rep) begin
                $display("%0t: table row %0d exp %p predicted %p", $time, k,
                         model_rep, pending_reports[$]);
                fail_count++;
            end
        end

        // extremes: zero spacing, oversized dims, negative origin
        set_grid(24'hFFFFF0, 24'hFFFFF0, 16'd0, 7'd127, 7'd127);
        send_word(OP_ADD, 24'hFFFFF0, 24'hFFFFF0, 16'h8001, 3'd7);
        random_words(150);
        set_grid(24'h800000, 24'h7FF000, 16'd65535, 7'd1, 7'd1);
        random_words(60);
        set_grid(24'd0, 24'd0, 16'd1, 7'd0, 7'd5);
        random_words(30);
        set_grid(24'h000100, 24'hFFFF00, 16'd3, 7'd10, 7'd12);
        random_words(300);

        // fill the block while the receiver holds off
        no_idle = 1'b1;
        drain_hold = 1'b1;
        fork
            begin
                repeat (3000) @(negedge i_clk);
                drain_hold = 1'b0;
            end
            random_words(8);
        join
        random_words(200);
        no_idle = 1'b0;

        // sender pause until all results are in
        sender_paused = 1'b1;
        wait_drained();
        sender_paused = 1'b0;

        set_grid(24'hFFFC00, 24'h000000, 16'd17, 7'd64, 7'd33);
        random_words(400);
        set_grid(24'd0, 24'd0, 16'd100, 7'd64, 7'd64);
        random_words(650);

        wait_drained();
        repeat (800) @(negedge i_clk);
        if (fail_count == 0 && pending_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

### sim.f
rtl/core/hgbt_pkg.sv
rtl/core/hgbt_ram.sv
rtl/core/hotspot_grid_brush_table_unit.sv
bench/tb_hotspot_grid_brush_table_unit.sv
